// ----- rtl/sc2a_pkg.sv -----
// shared types, codes and key tables for the scan code to ascii fifo
// no dependencies; used by the top level
package sc2a_pkg;

   // request function codes
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // shift make and break codes, set 1
   localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] RSHIFT_BREAK = 8'hB6;

   localparam int unsigned KEY_TABLE_LEN = 59;
   localparam int unsigned CHAR_W        = 7;

   localparam logic [CHAR_W-1:0] PLAIN_ROM [0:KEY_TABLE_LEN-1] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00
   };

   localparam logic [CHAR_W-1:0] SHIFTED_ROM [0:KEY_TABLE_LEN-1] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00
   };

   // pending read between ram address and output register
   typedef struct packed {
      logic valid;
      logic empty;
   } rd_pend_type;

   // character for a make code; zero means no character
   function automatic logic [CHAR_W-1:0] key_char(input logic [7:0] code,
                                                  input logic       shift);
      logic [CHAR_W-1:0] plain_c;
      logic [CHAR_W-1:0] shift_c;
      logic [5:0]        idx;
      idx     = code[5:0];
      plain_c = '0;
      shift_c = '0;
      if (code < 8'(KEY_TABLE_LEN)) begin
         plain_c = PLAIN_ROM[idx];
         shift_c = SHIFTED_ROM[idx];
      end
      if (shift && shift_c != '0) begin
         return shift_c;
      end
      return plain_c;
   endfunction

endpackage

// ----- rtl/sc2a_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// depends on nothing
module sc2a_ram #(
   parameter int unsigned WIDTH = 7,
   parameter int unsigned DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/scancode_to_ascii_fifo.sv -----
// scan code to ascii decoder with character fifo; needs sc2a_pkg and sc2a_ram
// a read beat's rsp beat comes through the ram read register, then the output register
// throughput: one req beat per cycle, scan codes and reads mixed freely
// any req beat waits while a read's ram data is stuck behind a stalled rsp beat
// reset: synchronous, active high; clears shift flag, pointers and pipeline valids
// character ram is not cleared; only entries already written are ever read
module scancode_to_ascii_fifo #(
   parameter int unsigned FIFO_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_data,
   output logic       rsp_is_empty
);

   localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

   // architectural state
   logic          shift_ff, shift_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;

   // read pipeline: pending entry waits on the ram output register
   sc2a_pkg::rd_pend_type pend_ff, pend_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_char_ff, rsp_char_in;
   logic       rsp_empty_ff, rsp_empty_in;

   logic          req_beat;
   logic          pend_adv;
   logic          fifo_empty;
   logic          fifo_full;
   logic [AW-1:0] wr_ptr_nxt;
   logic [AW-1:0] rd_ptr_nxt;
   logic [6:0]    key_c;
   logic          push;
   logic          pop;
   logic [6:0]    ram_rd_data;

   // pending read moves on when the output register is free or being drained
   assign pend_adv  = !rsp_valid_ff || rsp_ready;
   // hold off new beats only while a pending read cannot move on,
   // since a new read would overwrite the ram output register
   assign req_ready = !pend_ff.valid || pend_adv;
   assign req_beat  = req_valid && req_ready;

   assign wr_ptr_nxt = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_nxt = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
   assign fifo_empty = (rd_ptr_ff == wr_ptr_ff);
   // one slot always stays free, so full means write would catch up with read
   assign fifo_full  = (wr_ptr_nxt == rd_ptr_ff);

   // table lookup; break codes have bit 7 set and fall outside the table
   assign key_c = sc2a_pkg::key_char(req_scan_code, shift_ff);

   always_comb begin
      shift_in = shift_ff;
      push     = 1'b0;
      pop      = 1'b0;
      if (req_beat && req_func == sc2a_pkg::FUNC_SCAN) begin
         if (req_scan_code == sc2a_pkg::LSHIFT_MAKE ||
             req_scan_code == sc2a_pkg::RSHIFT_MAKE) begin
            shift_in = 1'b1;
         end else if (req_scan_code == sc2a_pkg::LSHIFT_BREAK ||
                      req_scan_code == sc2a_pkg::RSHIFT_BREAK) begin
            shift_in = 1'b0;
         end else if (key_c != '0 && !fifo_full) begin
            // full fifo drops the character
            push = 1'b1;
         end
      end
      if (req_beat && req_func == sc2a_pkg::FUNC_READ && !fifo_empty) begin
         pop = 1'b1;
      end
   end

   assign wr_ptr_in = push ? wr_ptr_nxt : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_nxt : rd_ptr_ff;

   // only one beat per cycle, so a write and a read never hit the ram together;
   // a read right after a write sees the new data through the registered read
   sc2a_ram #(
      .WIDTH (7),
      .DEPTH (FIFO_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (key_c),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      pend_in = pend_ff;
      if (pend_ff.valid && pend_adv) begin
         pend_in.valid = 1'b0;
      end
      if (req_beat && req_func == sc2a_pkg::FUNC_READ) begin
         pend_in.valid = 1'b1;
         pend_in.empty = fifo_empty;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_empty_in = rsp_empty_ff;
      if (pend_ff.valid && pend_adv) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = pend_ff.empty;
         rsp_char_in  = pend_ff.empty ? '0 : ram_rd_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_char_ff   <= rsp_char_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_data = rsp_char_ff;
   assign rsp_is_empty  = rsp_empty_ff;

endmodule

// ----- rtl/sc2a_checker.sv -----
// port-level checks for the scan code to ascii fifo, bound to its top level
// depends on scancode_to_ascii_fifo port names only
module sc2a_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_func,
   input logic [7:0] req_scan_code,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char_data,
   input logic       rsp_is_empty
);

   // a stalled req beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_func)
                                  && $stable(req_scan_code))
      else $error("req beat changed while stalled");

   // a stalled rsp beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_data)
                                  && $stable(rsp_is_empty))
      else $error("rsp beat changed while stalled");

   // empty answer carries a zero character
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_char_data == 7'd0)
      else $error("empty rsp with nonzero character");

   // only nonzero characters are ever buffered
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> rsp_char_data != 7'd0)
      else $error("buffered character is zero");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_func      (req_func),
   .req_scan_code (req_scan_code),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_char_data (rsp_char_data),
   .rsp_is_empty  (rsp_is_empty)
);
